[hw/rtl/pcmcv_pkg.sv]
// pcmcv_pkg: shared widths, mode codes and scale constants for the pcm sample converter
// no dependencies; compile first
package pcmcv_pkg;

	localparam int SampleW = 32;
	localparam int ModeW   = 3;
	localparam int HalfW   = 16;

	typedef logic [SampleW-1:0] sample_t;
	typedef logic [ModeW-1:0]   mode_t;

	// conversion mode codes
	localparam mode_t MODE_I16_F32 = 3'd0;
	localparam mode_t MODE_I32_F32 = 3'd1;
	localparam mode_t MODE_F32_I16 = 3'd2;
	localparam mode_t MODE_F32_I32 = 3'd3;
	localparam mode_t MODE_I16_I32 = 3'd4;
	localparam mode_t MODE_I32_I16 = 3'd5;

	// full scale divisors / multipliers
	localparam logic [30:0] Scale16 = 31'd32767;
	localparam logic [30:0] Scale32 = 31'h7FFF_FFFF;

endpackage

[hw/rtl/pcmcv_in_if.sv]
// pcmcv_in_if: valid/ready channel carrying one raw input sample word
// depends on pcmcv_pkg
interface pcmcv_in_if;
	import pcmcv_pkg::*;

	logic    valid;
	logic    ready;
	sample_t sample_bits;
	logic    in_last;

	modport source (output valid, output sample_bits, output in_last, input ready);
	modport sink (input valid, input sample_bits, input in_last, output ready);
endinterface

[hw/rtl/pcmcv_out_if.sv]
// pcmcv_out_if: valid/ready channel carrying one converted sample word
// depends on pcmcv_pkg
interface pcmcv_out_if;
	import pcmcv_pkg::*;

	logic    valid;
	logic    ready;
	sample_t result_bits;
	logic    saturated;
	logic    out_last;

	modport source (output valid, output result_bits, output saturated, output out_last,
		input ready);
	modport sink (input valid, input result_bits, input saturated, input out_last,
		output ready);
endinterface

[hw/rtl/pcmcv_i2f.sv]
// pcmcv_i2f: int16/int32 to binary32, divide by full scale with double then single rounding
// depends on pcmcv_pkg
module pcmcv_i2f (
	input  pcmcv_pkg::sample_t sample,
	input  logic               is32,
	output pcmcv_pkg::sample_t fbits
);
	import pcmcv_pkg::*;

	// repeating fraction 0.rrr... for a 15-bit period
	function automatic logic [94:0] rep15(input logic [14:0] r);
		logic [94:0] o;
		o = '0;
		for (int i = 0; i < 95; i++) begin
			o[94-i] = r[14 - (i % 15)];
		end
		return o;
	endfunction

	// repeating fraction 0.rrr... for a 31-bit period
	function automatic logic [94:0] rep31(input logic [30:0] r);
		logic [94:0] o;
		o = '0;
		for (int i = 0; i < 95; i++) begin
			o[94-i] = r[30 - (i % 31)];
		end
		return o;
	endfunction

	logic        neg;
	sample_t     sx;
	sample_t     mag;
	sample_t     divisor;
	logic        q;
	sample_t     rem;
	logic        rem_nz;
	logic [94:0] frac;
	logic [4:0]  lz;
	logic [5:0]  sh;
	logic [95:0] zs;
	logic [52:0] m53;
	logic        up1;
	logic [53:0] m54;
	logic [52:0] d53;
	logic [23:0] f24;
	logic        up2;
	logic [24:0] f25;
	logic [8:0]  exp_w;

	// sign and magnitude
	always_comb begin
		sx      = is32 ? sample : {{HalfW{sample[HalfW-1]}}, sample[HalfW-1:0]};
		neg     = sx[SampleW-1];
		mag     = neg ? (~sx + 32'd1) : sx;
		divisor = is32 ? {1'b0, Scale32} : {17'd0, Scale16[14:0]};
	end

	// integer part (0 or 1) and remainder, whose bits repeat as the fraction
	always_comb begin
		q      = (mag >= divisor);
		rem    = q ? (mag - divisor) : mag;
		rem_nz = |rem[30:0];
		frac   = is32 ? rep31(rem[30:0]) : rep15(rem[14:0]);
	end

	// leading zeros of the first period
	always_comb begin
		lz = 5'd30;
		for (int i = 30; i >= 0; i--) begin
			if (frac[94-i]) begin
				lz = 5'(i);
			end
		end
		sh = q ? 6'd0 : (6'(lz) + 6'd1);
		zs = {q, frac} << sh;
	end

	// round to 53 bits, then to 24 bits, both nearest-even
	always_comb begin
		m53 = zs[95:43];
		up1 = zs[42] & (rem_nz | m53[0]);
		m54 = {1'b0, m53} + 54'(up1);
		d53 = m54[53] ? {1'b1, 52'd0} : m54[52:0];
		f24 = d53[52:29];
		up2 = d53[28] & ((|d53[27:0]) | f24[0]);
		f25 = {1'b0, f24} + 25'(up2);
		exp_w = 9'd127 - 9'(sh) + 9'(m54[53]) + 9'(f25[24]);
		if (mag == '0) begin
			fbits = '0;
		end else begin
			fbits = {neg, exp_w[7:0], (f25[24] ? 23'd0 : f25[22:0])};
		end
	end

endmodule

[hw/rtl/pcmcv_f2i.sv]
// pcmcv_f2i: binary32 to int16/int32, multiply by full scale, round to double, truncate
// depends on pcmcv_pkg
module pcmcv_f2i (
	input  pcmcv_pkg::sample_t fbits,
	input  logic               is32,
	output pcmcv_pkg::sample_t ival,
	output logic               sat
);
	import pcmcv_pkg::*;

	logic              sgn;
	logic [7:0]        ex;
	logic [22:0]       fr;
	logic              is_nan;
	logic              is_inf;
	logic [23:0]       f_mant;
	logic signed [9:0] e;
	logic [30:0]       scale;
	logic [54:0]       prod;
	logic [52:0]       base;
	logic              g;
	logic              s;
	logic signed [9:0] k;
	logic              up;
	logic [53:0]       xr;
	logic [9:0]        nk;
	logic [53:0]       t;
	logic              huge;
	logic [32:0]       mag;
	logic [32:0]       lim_pos;
	logic [32:0]       lim_neg;
	sample_t           sat_hi;
	sample_t           sat_lo;
	sample_t           mask;
	sample_t           signed_val;

	// unpack
	always_comb begin
		sgn    = fbits[31];
		ex     = fbits[30:23];
		fr     = fbits[22:0];
		is_nan = (ex == 8'hFF) && (fr != '0);
		is_inf = (ex == 8'hFF) && (fr == '0);
		f_mant = {(ex != 8'd0), fr};
		e      = $signed({2'b00, ((ex == 8'd0) ? 8'd1 : ex)}) - 10'sd150;
		scale  = is32 ? Scale32 : Scale16;
	end

	// exact product
	assign prod = 55'(f_mant) * 55'(scale);

	// round product to 53 significant bits, nearest-even
	always_comb begin
		if (prod[54]) begin
			base = prod[54:2];
			g    = prod[1];
			s    = prod[0];
			k    = e + 10'sd2;
		end else if (prod[53]) begin
			base = prod[53:1];
			g    = prod[0];
			s    = 1'b0;
			k    = e + 10'sd1;
		end else begin
			base = prod[52:0];
			g    = 1'b0;
			s    = 1'b0;
			k    = e;
		end
		up = g & (s | base[0]);
		xr = {1'b0, base} + 54'(up);
	end

	// truncate toward zero
	always_comb begin
		nk = 10'(-k);
		if (k >= 10'sd0) begin
			t    = '0;
			huge = (xr != '0);
		end else begin
			t    = (nk >= 10'd54) ? '0 : (xr >> nk[5:0]);
			huge = |t[53:33];
		end
		mag = t[32:0];
	end

	// clamp and sign
	always_comb begin
		lim_pos    = is32 ? 33'h0_8000_0000 : 33'h0_0000_8000;
		lim_neg    = is32 ? 33'h0_8000_0001 : 33'h0_0000_8001;
		sat_hi     = is32 ? 32'h7FFF_FFFF : 32'h0000_7FFF;
		sat_lo     = is32 ? 32'h8000_0000 : 32'h0000_8000;
		mask       = is32 ? 32'hFFFF_FFFF : 32'h0000_FFFF;
		signed_val = sgn ? (~mag[31:0] + 32'd1) : mag[31:0];
		priority if (is_nan) begin
			ival = '0;
			sat  = 1'b1;
		end else if (is_inf || huge) begin
			ival = sgn ? sat_lo : sat_hi;
			sat  = 1'b1;
		end else if (!sgn && (mag >= lim_pos)) begin
			ival = sat_hi;
			sat  = 1'b1;
		end else if (sgn && (mag >= lim_neg)) begin
			ival = sat_lo;
			sat  = 1'b1;
		end else begin
			ival = signed_val & mask;
			sat  = 1'b0;
		end
	end

endmodule

[hw/rtl/pcm_sample_format_converter_top.sv]
// Converts one mono PCM word per clock between int16, int32 and binary32 as set by the
// 3-bit conversion mode register (write it only while no words are in flight). A word
// accepted on sample_ch is loaded into the input register, then through the converter
// logic into the result register that drives result_ch. With result_ch ready the block
// takes and delivers one word every clock; a stall on result_ch holds the result register
// and a word in the input register, and backs up to sample_ch. Unused mode codes give zero.
// depends on pcmcv_pkg, pcmcv_in_if, pcmcv_out_if, pcmcv_i2f, pcmcv_f2i
module pcm_sample_format_converter_top (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_wr_en,
	input  pcmcv_pkg::mode_t       cfg_wr_data,
	pcmcv_in_if.sink               sample_ch,
	pcmcv_out_if.source            result_ch
);
	import pcmcv_pkg::*;

	mode_t   conversion_mode_q;
	logic    valid_s1;
	sample_t sample_s1;
	logic    last_s1;
	logic    valid_s2;
	sample_t result_s2;
	logic    sat_s2;
	logic    last_s2;
	logic    adv1;
	logic    adv2;
	sample_t i2f_bits;
	sample_t f2i_bits;
	logic    f2i_sat;
	sample_t res_d;
	logic    sat_d;

	// mode register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			conversion_mode_q <= MODE_I16_F32;
		end else if (cfg_wr_en) begin
			conversion_mode_q <= cfg_wr_data;
		end
	end

	// pipeline flow
	assign adv2            = !valid_s2 || result_ch.ready;
	assign adv1            = !valid_s1 || adv2;
	assign sample_ch.ready = adv1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (adv1) begin
				valid_s1 <= sample_ch.valid;
			end
			if (adv2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (adv1 && sample_ch.valid) begin
			sample_s1 <= sample_ch.sample_bits;
			last_s1   <= sample_ch.in_last;
		end
		if (adv2 && valid_s1) begin
			result_s2 <= res_d;
			sat_s2    <= sat_d;
			last_s2   <= last_s1;
		end
	end

	// converters
	pcmcv_i2f u_i2f (
		.sample (sample_s1),
		.is32   (conversion_mode_q == MODE_I32_F32),
		.fbits  (i2f_bits)
	);

	pcmcv_f2i u_f2i (
		.fbits (sample_s1),
		.is32  (conversion_mode_q == MODE_F32_I32),
		.ival  (f2i_bits),
		.sat   (f2i_sat)
	);

	// result select
	always_comb begin
		sat_d = 1'b0;
		unique case (conversion_mode_q)
			MODE_I16_F32, MODE_I32_F32: res_d = i2f_bits;
			MODE_F32_I16, MODE_F32_I32: begin
				res_d = f2i_bits;
				sat_d = f2i_sat;
			end
			MODE_I16_I32: res_d = {sample_s1[HalfW-1:0], {HalfW{1'b0}}};
			MODE_I32_I16: res_d = {{HalfW{1'b0}}, sample_s1[SampleW-1:HalfW]};
			default:      res_d = '0;
		endcase
	end

	assign result_ch.valid       = valid_s2;
	assign result_ch.result_bits = result_s2;
	assign result_ch.saturated   = sat_s2;
	assign result_ch.out_last    = last_s2;

	// checks
	a_sat_only_f2i: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && !(conversion_mode_q == MODE_F32_I16 ||
			conversion_mode_q == MODE_F32_I32) |-> !sat_s2)
		else $error("saturated set outside float to integer modes");

	a_i16_upper_zero: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && (conversion_mode_q == MODE_F32_I16 ||
			conversion_mode_q == MODE_I32_I16) |-> (result_s2[SampleW-1:HalfW] == '0))
		else $error("int16 result with upper half set");

	a_moves_forward: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !valid_s2 |=> valid_s2)
		else $error("word stuck in input register");

	a_last_follows: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && adv2 |=> (last_s2 == $past(last_s1)))
		else $error("last mark lost between stages");

endmodule
